### sv/kmcu_pkg.sv
// Package for the k-means centroid update block: sizes, payload structs,
// register indexes and the sequencer state type. No dependencies.
package kmcu_pkg;

	localparam int MAX_CLUSTERS = 8;
	localparam int MAX_DIMS     = 8;
	localparam int CL_W         = 3;
	localparam int DIM_W        = 3;
	localparam int ADDR_W       = CL_W + DIM_W;
	localparam int DEPTH        = MAX_CLUSTERS * MAX_DIMS;
	localparam int SUM_W        = 32;
	localparam int CNT_W        = 17;
	localparam int VAL_W        = 16;
	localparam int CFG_W        = 4;
	localparam int CFG_IDX_W    = 4;
	localparam int BIT_W        = 5;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS     = CFG_IDX_W'(1);

	localparam logic ACT_ACCUM = 1'b0;
	localparam logic ACT_INIT  = 1'b1;

	typedef struct packed {
		logic             action;
		logic [CL_W-1:0]  cluster;
		logic [VAL_W-1:0] value;
		logic             last_of_pass;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] centroid_value;
		logic [CL_W-1:0]  centroid_index;
		logic [DIM_W-1:0] dim_index;
		logic             changed;
		logic             last;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC_WR,
		ST_UPD_RD,
		ST_UPD_LD,
		ST_UPD_DIV,
		ST_UPD_WR,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

endpackage

### sv/kmeans_centroid_update_top.sv
// K-means centroid update: accumulates coordinate sums and point counts and, at the
// end of a pass, divides them into new centroids and streams them out.
// Depends on kmcu_pkg.
//
// Usage: send one coordinate per request, point by point, tagged with the point's
// cluster; set last_of_pass on the final coordinate. A request with action set
// loads centroid c with (c,0,...,0) and clears the accumulators, emitting nothing.
// Flow: a coordinate for an out-of-use cluster is taken without a memory access;
// else it is read, then saturating-added and written back to the sum memory, and
// no request is taken before that write-back. The closing coordinate then starts
// the update pass on one shared radix-2 restoring divider: each in-use centroid
// coordinate is read, loaded, divided in 32 steps and written back; a cluster with
// no points skips the divide steps. Results are read and loaded in turn into the
// output register, cluster-major with the dimension fastest, waiting while it is
// full. No request is taken from the closing coordinate until the last is loaded.
// Sums and centroids sit in 64-entry memories with per-entry valid flags, so
// reset, init and the end-of-pass clear take effect at once: no clearing pass.
module kmeans_centroid_update_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  kmcu_pkg::req_t                  req_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output kmcu_pkg::rsp_t                  rsp_data,
	input  logic                            cfg_we,
	input  logic [kmcu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [kmcu_pkg::CFG_W-1:0]      cfg_data
);

	kmcu_pkg::state_t state_q, nxt_state;

	// configuration
	logic [kmcu_pkg::CFG_W-1:0] num_clusters_q, num_dims_q;
	logic [kmcu_pkg::CFG_W-1:0] nc_clamp, nd_clamp;
	logic [kmcu_pkg::CL_W-1:0]  nc_last;
	logic [kmcu_pkg::DIM_W-1:0] nd_last;

	// accumulation state
	logic [kmcu_pkg::DIM_W-1:0] dim_q;
	logic [kmcu_pkg::CNT_W-1:0] cnt_q [kmcu_pkg::MAX_CLUSTERS];
	logic [kmcu_pkg::DEPTH-1:0] sum_vld_q;
	logic [kmcu_pkg::DEPTH-1:0] cent_vld_q;
	logic                       init_q;

	// memories and read ports
	logic [kmcu_pkg::SUM_W-1:0] sum_mem  [kmcu_pkg::DEPTH];
	logic [kmcu_pkg::VAL_W-1:0] cent_mem [kmcu_pkg::DEPTH];
	logic [kmcu_pkg::SUM_W-1:0] sum_rd_q;
	logic [kmcu_pkg::VAL_W-1:0] cent_rd_q;
	logic [kmcu_pkg::VAL_W-1:0] cent_dflt;
	logic [kmcu_pkg::ADDR_W-1:0] rd_addr;
	logic                        rd_en;

	// captured request
	logic [kmcu_pkg::ADDR_W-1:0] acc_addr_q;
	logic [kmcu_pkg::VAL_W-1:0]  acc_val_q;
	logic                        acc_last_q;

	// update and emit sequencing
	logic [kmcu_pkg::CL_W-1:0]  c_q;
	logic [kmcu_pkg::DIM_W-1:0] d_q;
	logic                       changed_q;
	logic [kmcu_pkg::CNT_W-1:0] div_cnt_q;
	logic [kmcu_pkg::VAL_W-1:0] old_q;
	logic [kmcu_pkg::SUM_W-1:0] quo_q;
	logic [kmcu_pkg::CNT_W-1:0] rem_q;
	logic [kmcu_pkg::BIT_W-1:0] bit_q;
	logic                       walk_last;

	// output register
	logic           out_valid_q;
	kmcu_pkg::rsp_t out_q;

	// request decode
	logic                       accept, acc_go, in_use, point_end;
	logic [kmcu_pkg::DIM_W-1:0] d_eff;
	logic [kmcu_pkg::SUM_W:0]   sum_add;
	logic [kmcu_pkg::CNT_W:0]   rem_shift;
	logic [kmcu_pkg::VAL_W-1:0] new_val;
	logic                       out_free;

	// clamp registers to their legal range when used
	always_comb begin
		nc_clamp = num_clusters_q;
		if (num_clusters_q == '0) nc_clamp = kmcu_pkg::CFG_W'(1);
		else if (num_clusters_q > kmcu_pkg::CFG_W'(kmcu_pkg::MAX_CLUSTERS))
			nc_clamp = kmcu_pkg::CFG_W'(kmcu_pkg::MAX_CLUSTERS);
		nd_clamp = num_dims_q;
		if (num_dims_q == '0) nd_clamp = kmcu_pkg::CFG_W'(1);
		else if (num_dims_q > kmcu_pkg::CFG_W'(kmcu_pkg::MAX_DIMS))
			nd_clamp = kmcu_pkg::CFG_W'(kmcu_pkg::MAX_DIMS);
	end
	assign nc_last = kmcu_pkg::CL_W'(nc_clamp - kmcu_pkg::CFG_W'(1));
	assign nd_last = kmcu_pkg::DIM_W'(nd_clamp - kmcu_pkg::CFG_W'(1));

	assign req_ready = (state_q == kmcu_pkg::ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign acc_go    = accept && (req_data.action == kmcu_pkg::ACT_ACCUM);

	// a lowered dimension count folds a running point onto its last coordinate
	assign d_eff     = (dim_q > nd_last) ? nd_last : dim_q;
	assign in_use    = (req_data.cluster <= nc_last);
	assign point_end = (d_eff == nd_last) || req_data.last_of_pass;

	assign sum_add   = {1'b0, sum_rd_q} + {{(kmcu_pkg::SUM_W+1-kmcu_pkg::VAL_W){1'b0}}, acc_val_q};
	assign rem_shift = {rem_q, quo_q[kmcu_pkg::SUM_W-1]};
	assign walk_last = (c_q == nc_last) && (d_q == nd_last);
	assign out_free  = !out_valid_q || rsp_ready;

	// an empty cluster keeps its centroid; quotients saturate at full scale
	always_comb begin
		if (div_cnt_q == '0) new_val = old_q;
		else if (quo_q[kmcu_pkg::SUM_W-1:kmcu_pkg::VAL_W] != '0) new_val = '1;
		else new_val = quo_q[kmcu_pkg::VAL_W-1:0];
	end

	// next state and read port control
	always_comb begin
		nxt_state = state_q;
		rd_en     = 1'b0;
		rd_addr   = {c_q, d_q};
		unique case (state_q)
			kmcu_pkg::ST_IDLE: begin
				rd_addr = {req_data.cluster, d_eff};
				if (acc_go) begin
					if (in_use) begin
						rd_en     = 1'b1;
						nxt_state = kmcu_pkg::ST_ACC_WR;
					end else if (req_data.last_of_pass) begin
						nxt_state = kmcu_pkg::ST_UPD_RD;
					end
				end
			end
			kmcu_pkg::ST_ACC_WR: begin
				nxt_state = acc_last_q ? kmcu_pkg::ST_UPD_RD : kmcu_pkg::ST_IDLE;
			end
			kmcu_pkg::ST_UPD_RD: begin
				rd_en     = 1'b1;
				nxt_state = kmcu_pkg::ST_UPD_LD;
			end
			kmcu_pkg::ST_UPD_LD: begin
				nxt_state = (cnt_q[c_q] == '0) ? kmcu_pkg::ST_UPD_WR : kmcu_pkg::ST_UPD_DIV;
			end
			kmcu_pkg::ST_UPD_DIV: begin
				if (bit_q == '1) nxt_state = kmcu_pkg::ST_UPD_WR;
			end
			kmcu_pkg::ST_UPD_WR: begin
				nxt_state = walk_last ? kmcu_pkg::ST_EMIT_RD : kmcu_pkg::ST_UPD_RD;
			end
			kmcu_pkg::ST_EMIT_RD: begin
				rd_en     = 1'b1;
				nxt_state = kmcu_pkg::ST_EMIT_LD;
			end
			kmcu_pkg::ST_EMIT_LD: begin
				if (out_free)
					nxt_state = walk_last ? kmcu_pkg::ST_IDLE : kmcu_pkg::ST_EMIT_RD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= kmcu_pkg::ST_IDLE;
		else state_q <= nxt_state;
	end

	// configuration port; indexes beyond the list drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_clusters_q <= kmcu_pkg::CFG_W'(1);
			num_dims_q     <= kmcu_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == kmcu_pkg::REG_NUM_CLUSTERS) num_clusters_q <= cfg_data;
			else if (cfg_index == kmcu_pkg::REG_NUM_DIMS) num_dims_q <= cfg_data;
		end
	end

	// accumulator control: dimension counter, point counts, valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q      <= '0;
			sum_vld_q  <= '0;
			cent_vld_q <= '0;
			init_q     <= 1'b0;
			for (int i = 0; i < kmcu_pkg::MAX_CLUSTERS; i++) cnt_q[i] <= '0;
		end else begin
			if (accept && (req_data.action == kmcu_pkg::ACT_INIT)) begin
				// centroids fall back to (c,0,...,0) until rewritten
				dim_q      <= '0;
				sum_vld_q  <= '0;
				cent_vld_q <= '0;
				init_q     <= 1'b1;
				for (int i = 0; i < kmcu_pkg::MAX_CLUSTERS; i++) cnt_q[i] <= '0;
			end else if (acc_go) begin
				dim_q <= point_end ? '0 : d_eff + kmcu_pkg::DIM_W'(1);
				if (point_end && in_use && (cnt_q[req_data.cluster] != '1))
					cnt_q[req_data.cluster] <= cnt_q[req_data.cluster] + kmcu_pkg::CNT_W'(1);
			end
			if (state_q == kmcu_pkg::ST_ACC_WR) sum_vld_q[acc_addr_q] <= 1'b1;
			if (state_q == kmcu_pkg::ST_UPD_WR) begin
				cent_vld_q[{c_q, d_q}] <= 1'b1;
				if (walk_last) begin
					// pass done: clear sums and counts for the next pass
					dim_q     <= '0;
					sum_vld_q <= '0;
					for (int i = 0; i < kmcu_pkg::MAX_CLUSTERS; i++) cnt_q[i] <= '0;
				end
			end
		end
	end

	// default value of a centroid entry that was never written
	always_comb begin
		cent_dflt = '0;
		if (init_q && (rd_addr[kmcu_pkg::DIM_W-1:0] == '0))
			cent_dflt = kmcu_pkg::VAL_W'(rd_addr[kmcu_pkg::ADDR_W-1:kmcu_pkg::DIM_W]);
	end

	// sum memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (state_q == kmcu_pkg::ST_ACC_WR)
			sum_mem[acc_addr_q] <= sum_add[kmcu_pkg::SUM_W] ? '1 : sum_add[kmcu_pkg::SUM_W-1:0];
		if (rd_en) sum_rd_q <= sum_vld_q[rd_addr] ? sum_mem[rd_addr] : '0;
	end

	// centroid memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (state_q == kmcu_pkg::ST_UPD_WR) cent_mem[{c_q, d_q}] <= new_val;
		if (rd_en) cent_rd_q <= cent_vld_q[rd_addr] ? cent_mem[rd_addr] : cent_dflt;
	end

	// capture the accepted coordinate
	always_ff @(posedge clk) begin
		if (acc_go) begin
			acc_addr_q <= {req_data.cluster, d_eff};
			acc_val_q  <= req_data.value;
			acc_last_q <= req_data.last_of_pass;
		end
	end

	// walk counters over in-use clusters and dimensions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			d_q <= '0;
		end else if ((nxt_state == kmcu_pkg::ST_UPD_RD) &&
		             (state_q == kmcu_pkg::ST_IDLE || state_q == kmcu_pkg::ST_ACC_WR)) begin
			c_q <= '0;
			d_q <= '0;
		end else if ((state_q == kmcu_pkg::ST_UPD_WR) ||
		             (state_q == kmcu_pkg::ST_EMIT_LD && out_free)) begin
			if (walk_last) begin
				c_q <= '0;
				d_q <= '0;
			end else if (d_q == nd_last) begin
				c_q <= c_q + kmcu_pkg::CL_W'(1);
				d_q <= '0;
			end else begin
				d_q <= d_q + kmcu_pkg::DIM_W'(1);
			end
		end
	end

	// shared divider: sum / count, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if ((nxt_state == kmcu_pkg::ST_UPD_RD) &&
		    (state_q == kmcu_pkg::ST_IDLE || state_q == kmcu_pkg::ST_ACC_WR))
			changed_q <= 1'b0;
		unique case (state_q)
			kmcu_pkg::ST_UPD_LD: begin
				div_cnt_q <= cnt_q[c_q];
				old_q     <= cent_rd_q;
				quo_q     <= sum_rd_q;
				rem_q     <= '0;
				bit_q     <= '0;
			end
			kmcu_pkg::ST_UPD_DIV: begin
				bit_q <= bit_q + kmcu_pkg::BIT_W'(1);
				if (rem_shift >= {1'b0, div_cnt_q}) begin
					rem_q <= kmcu_pkg::CNT_W'(rem_shift - {1'b0, div_cnt_q});
					quo_q <= {quo_q[kmcu_pkg::SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_shift[kmcu_pkg::CNT_W-1:0];
					quo_q <= {quo_q[kmcu_pkg::SUM_W-2:0], 1'b0};
				end
			end
			kmcu_pkg::ST_UPD_WR: begin
				if (new_val != old_q) changed_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	// output register: hold until taken, load the next centroid coordinate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (state_q == kmcu_pkg::ST_EMIT_LD && out_free) out_valid_q <= 1'b1;
		else if (rsp_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == kmcu_pkg::ST_EMIT_LD && out_free) begin
			out_q.centroid_value <= cent_rd_q;
			out_q.centroid_index <= c_q;
			out_q.dim_index      <= d_q;
			out_q.changed        <= changed_q;
			out_q.last           <= walk_last;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule
